/* src/ccl_pkg.sv */
// Shared types and constants of the code/comment line counter.
// Used by ccl_scan and code_comment_line_counter_core.
package ccl_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    ST_LINE_START  = 3'd0,
    ST_CODE        = 3'd1,
    ST_SLASH       = 3'd2,
    ST_LINE_CMT    = 3'd3,
    ST_BLOCK       = 3'd4,
    ST_STAR        = 3'd5,
    ST_AFTER_END   = 3'd6,
    ST_AFTER_SLASH = 3'd7
  } scan_state_t;

  // One item as presented to the scanner.
  typedef struct packed {
    logic       take;
    logic       op;
    logic [7:0] ch;
  } ccl_item_t;

  // Line events raised by the scanner for the item it takes.
  typedef struct packed {
    logic code_line;
    logic cmt_line;
  } ccl_evt_t;

endpackage

/* src/ccl_scan.sv */
// Line scanner: eight-state comment recognizer that flags finished lines.
// Depends on ccl_pkg.
module ccl_scan
  import ccl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ccl_item_t item,
  output ccl_evt_t  evt
);

  scan_state_t state_r, state_nxt;
  logic        nl;
  logic        blank;

  assign nl    = (item.ch == CH_NEWLINE);
  assign blank = nl || (item.ch == CH_SPACE) || (item.ch == CH_TAB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LINE_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (item.take) begin
      if (item.op == OP_EOF) begin
        state_nxt = ST_LINE_START;
      end else begin
        unique case (state_r)
          ST_LINE_START: begin
            if (blank)                      state_nxt = ST_LINE_START;
            else if (item.ch == CH_SLASH)   state_nxt = ST_SLASH;
            else                            state_nxt = ST_CODE;
          end
          ST_CODE: begin
            if (nl) state_nxt = ST_LINE_START;
          end
          ST_SLASH: begin
            if (nl)                         state_nxt = ST_LINE_START;
            else if (item.ch == CH_SLASH)   state_nxt = ST_LINE_CMT;
            else if (item.ch == CH_STAR)    state_nxt = ST_BLOCK;
            else                            state_nxt = ST_CODE;
          end
          ST_LINE_CMT: begin
            if (nl) state_nxt = ST_LINE_START;
          end
          ST_BLOCK: begin
            if (!nl && item.ch == CH_STAR) state_nxt = ST_STAR;
          end
          ST_STAR: begin
            if (nl)                         state_nxt = ST_BLOCK;
            else if (item.ch == CH_SLASH)   state_nxt = ST_AFTER_END;
            else if (item.ch == CH_STAR)    state_nxt = ST_STAR;
            else                            state_nxt = ST_BLOCK;
          end
          ST_AFTER_END: begin
            if (nl)                         state_nxt = ST_LINE_START;
            else if (item.ch == CH_SLASH)   state_nxt = ST_AFTER_SLASH;
          end
          ST_AFTER_SLASH: begin
            if (nl)                         state_nxt = ST_LINE_START;
            else if (item.ch == CH_STAR)    state_nxt = ST_BLOCK;
          end
          default: state_nxt = ST_LINE_START;
        endcase
      end
    end
  end

  // Line events: newline closes a line, end of file closes a pending one
  always_comb begin
    evt = '0;
    if (item.take) begin
      if (item.op == OP_EOF) begin
        evt.code_line = (state_r == ST_CODE) || (state_r == ST_SLASH);
        evt.cmt_line  = (state_r != ST_CODE) && (state_r != ST_SLASH) &&
                        (state_r != ST_LINE_START);
      end else if (nl) begin
        evt.code_line = (state_r == ST_CODE) || (state_r == ST_SLASH);
        evt.cmt_line  = (state_r != ST_CODE) && (state_r != ST_SLASH) &&
                        (state_r != ST_LINE_START);
      end
    end
  end

  a_evt_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.code_line && evt.cmt_line))
    else $error("code and comment line flagged together");

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (item.take && item.op == OP_EOF) |=> (state_r == ST_LINE_START))
    else $error("scanner not back at line start after end of file");

  a_no_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !item.take |-> (evt == '0))
    else $error("line event without an item");

endmodule

/* src/code_comment_line_counter_core.sv */
// Top level of the code/comment line counter: input register, scanner,
// saturating counters and result register.
// Depends on ccl_pkg and ccl_scan.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_op, in_ch        | input
//   out     | out_valid, out_ready, out_code_lines,   | output
//           | out_comment_lines, out_total_lines      |
//
// One item per cycle while in_ready is high. An item is registered in the input
// register, then scanned; an end-of-file item is scanned only once the result
// register is free or being taken, and then loads the result register and
// raises out_valid.
// Reset puts the scanner at line start with both counters at zero.
// in_ready drops only while the input register holds an end-of-file item and
// the result register still holds a result not yet taken.
module code_comment_line_counter_core
  import ccl_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [7:0]          in_ch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_code_lines,
  output logic [OUT_BITS-1:0] out_comment_lines,
  output logic [OUT_BITS-1:0] out_total_lines
);

  localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  logic                  s0_valid_r, s0_valid_nxt;
  logic                  s0_op_r;
  logic [7:0]            s0_ch_r;
  logic                  adv;
  logic                  take;
  logic                  in_take;
  ccl_item_t             item;
  ccl_evt_t              evt;

  logic [COUNT_BITS-1:0] code_r, code_nxt, code_upd;
  logic [COUNT_BITS-1:0] cmt_r, cmt_nxt, cmt_upd;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] total;
  logic [WIDE_BITS-1:0]  code_w, cmt_w, total_w;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]   out_code_r, out_cmt_r, out_total_r;

  // Input register advances unless an end-of-file item waits for the result slot
  assign adv      = (s0_op_r != OP_EOF) || !out_valid_r || out_ready;
  assign take     = s0_valid_r && adv;
  assign in_ready = !s0_valid_r || adv;
  assign in_take  = in_valid && in_ready;

  assign s0_valid_nxt = in_take ? 1'b1 : (take ? 1'b0 : s0_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_op_r <= in_op;
      s0_ch_r <= in_ch;
    end
  end

  assign item.take = take;
  assign item.op   = s0_op_r;
  assign item.ch   = s0_ch_r;

  ccl_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .evt   (evt)
  );

  // Saturating increments
  assign code_upd = (evt.code_line && code_r != '1) ? code_r + COUNT_BITS'(1) : code_r;
  assign cmt_upd  = (evt.cmt_line && cmt_r != '1) ? cmt_r + COUNT_BITS'(1) : cmt_r;

  assign sum   = {1'b0, code_upd} + {1'b0, cmt_upd};
  assign total = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

  // Widen to the larger of the counter and result widths before clamping to the result width
  assign code_w  = WIDE_BITS'(code_upd);
  assign cmt_w   = WIDE_BITS'(cmt_upd);
  assign total_w = WIDE_BITS'(total);

  // End of file hands the counts over and clears them for the next file
  always_comb begin
    code_nxt = code_upd;
    cmt_nxt  = cmt_upd;
    if (take && s0_op_r == OP_EOF) begin
      code_nxt = '0;
      cmt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      cmt_r  <= '0;
    end else begin
      code_r <= code_nxt;
      cmt_r  <= cmt_nxt;
    end
  end

  assign out_valid_nxt = (take && s0_op_r == OP_EOF) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s0_op_r == OP_EOF) begin
      out_code_r  <= (code_w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : code_w[OUT_BITS-1:0];
      out_cmt_r   <= (cmt_w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : cmt_w[OUT_BITS-1:0];
      out_total_r <= (total_w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : total_w[OUT_BITS-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_lines    = out_code_r;
  assign out_comment_lines = out_cmt_r;
  assign out_total_lines   = out_total_r;

  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s0_op_r == OP_EOF) |=> (code_r == '0 && cmt_r == '0))
    else $error("counters not cleared after end of file");

  a_result_from_eof: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && s0_op_r == OP_EOF))
    else $error("result raised without an end-of-file item");

  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_total_r >= out_code_r && out_total_r >= out_cmt_r))
    else $error("total below one of its parts");

endmodule

/* tb/tb_code_comment_line_counter_core.sv */
// Testbench for code_comment_line_counter_core: byte streams of C-like text,
// end-of-file items, and a scoreboard that predicts the line counts.
// Depends on ccl_pkg and the counter RTL.
module tb_code_comment_line_counter_core;
  import ccl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_ITEMS   = 1850;
  localparam int PRESSURE_AT    = 900;
  localparam int PRESSURE_HOLD  = 400;
  localparam int PRESSURE_FILES = 30;

  typedef logic [COUNT_BITS_DEF-1:0] count_t;

  class line_tally_board;
    typedef struct {
      count_t code;
      count_t cmt;
      count_t total;
    } tally_t;

    scan_state_t state;
    count_t      code_cnt;
    count_t      cmt_cnt;
    tally_t      tally_q[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      state    = ST_LINE_START;
      code_cnt = '0;
      cmt_cnt  = '0;
    endfunction

    function count_t bump(count_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void scan(logic [7:0] ch);
      logic nl;
      nl = (ch == CH_NEWLINE);
      case (state)
        ST_LINE_START: begin
          if (ch == CH_SPACE || ch == CH_TAB || nl) state = ST_LINE_START;
          else if (ch == CH_SLASH) state = ST_SLASH;
          else state = ST_CODE;
        end
        ST_CODE: begin
          if (nl) begin
            code_cnt = bump(code_cnt);
            state = ST_LINE_START;
          end
        end
        ST_SLASH: begin
          if (nl) begin
            code_cnt = bump(code_cnt);
            state = ST_LINE_START;
          end else if (ch == CH_SLASH) state = ST_LINE_CMT;
          else if (ch == CH_STAR) state = ST_BLOCK;
          else state = ST_CODE;
        end
        ST_LINE_CMT: begin
          if (nl) begin
            cmt_cnt = bump(cmt_cnt);
            state = ST_LINE_START;
          end
        end
        ST_BLOCK: begin
          if (nl) cmt_cnt = bump(cmt_cnt);
          else if (ch == CH_STAR) state = ST_STAR;
        end
        ST_STAR: begin
          if (nl) begin
            cmt_cnt = bump(cmt_cnt);
            state = ST_BLOCK;
          end else if (ch == CH_SLASH) state = ST_AFTER_END;
          else if (ch == CH_STAR) state = ST_STAR;
          else state = ST_BLOCK;
        end
        ST_AFTER_END: begin
          if (nl) begin
            cmt_cnt = bump(cmt_cnt);
            state = ST_LINE_START;
          end else if (ch == CH_SLASH) state = ST_AFTER_SLASH;
        end
        default: begin
          if (nl) begin
            cmt_cnt = bump(cmt_cnt);
            state = ST_LINE_START;
          end else if (ch == CH_STAR) state = ST_BLOCK;
        end
      endcase
    endfunction

    // Scan a data item; an end-of-file item closes the pending line, queues the counts, starts the next file.
    function void note_input(logic op, logic [7:0] ch);
      tally_t t;
      logic [COUNT_BITS_DEF:0] sum;
      if (op == OP_DATA) begin
        scan(ch);
        return;
      end
      if (state == ST_CODE || state == ST_SLASH) code_cnt = bump(code_cnt);
      else if (state != ST_LINE_START) cmt_cnt = bump(cmt_cnt);
      sum     = {1'b0, code_cnt} + {1'b0, cmt_cnt};
      t.code  = code_cnt;
      t.cmt   = cmt_cnt;
      t.total = sum[COUNT_BITS_DEF] ? '1 : sum[COUNT_BITS_DEF-1:0];
      tally_q.push_back(t);
      clear();
    endfunction

    function int pending();
      return tally_q.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_BITS-1:0] code, logic [OUT_BITS-1:0] cmt,
                      logic [OUT_BITS-1:0] total);
      tally_t t;
      if (tally_q.size() == 0) begin
        report($sformatf("unexpected result code=%0d comment=%0d total=%0d",
                         code, cmt, total));
        return;
      end
      t = tally_q.pop_front();
      if (code !== t.code)
        report($sformatf("code_lines %0d, expected %0d", code, t.code));
      if (cmt !== t.cmt)
        report($sformatf("comment_lines %0d, expected %0d", cmt, t.cmt));
      if (total !== t.total)
        report($sformatf("total_lines %0d, expected %0d", total, t.total));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_DATA;
  logic [7:0]          in_ch = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_BITS-1:0] out_code_lines;
  logic [OUT_BITS-1:0] out_comment_lines;
  logic [OUT_BITS-1:0] out_total_lines;

  line_tally_board sb = new();
  int         items_sent = 0;
  bit         idle_on = 1'b1;
  bit         pressure_go = 1'b0;
  logic [7:0] file_bytes[$];

  code_comment_line_counter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_lines   (out_code_lines),
    .out_comment_lines(out_comment_lines),
    .out_total_lines  (out_total_lines)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(logic op, logic [7:0] ch);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_ch    <= ch;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, ch);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_DATA, s[i]);
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 15))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_SPACE;
      3: return CH_TAB;
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_NEWLINE;
      3: return CH_TAB;
      4: return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function void push_text(int lo, int hi);
    repeat ($urandom_range(lo, hi)) file_bytes.push_back(text_byte());
  endfunction

  function void push_pad();
    repeat ($urandom_range(0, 2))
      file_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function void push_block_body();
    file_bytes.push_back(CH_SLASH);
    file_bytes.push_back(CH_STAR);
    repeat ($urandom_range(0, 2)) begin
      push_text(0, 5);
      file_bytes.push_back(CH_NEWLINE);
    end
    push_text(0, 5);
    repeat ($urandom_range(1, 3)) file_bytes.push_back(CH_STAR);
    file_bytes.push_back(CH_SLASH);
  endfunction

  function void push_line(bit last);
    logic [7:0] lead;
    push_pad();
    case ($urandom_range(0, 9))
      0: ;
      1, 2: begin
        lead = 8'($urandom_range(8'h21, 8'h7E));
        file_bytes.push_back(lead == CH_SLASH ? 8'h3B : lead);
        push_text(0, 8);
      end
      3: begin
        file_bytes.push_back(CH_SLASH);
        file_bytes.push_back(CH_SLASH);
        push_text(0, 6);
      end
      4, 5: begin
        push_block_body();
        case ($urandom_range(0, 3))
          0: ;
          1: push_text(1, 4);
          2: begin
            // Reopen a block comment right after closing one.
            file_bytes.push_back(CH_SLASH);
            file_bytes.push_back(CH_STAR);
            push_text(0, 4);
            if ($urandom_range(0, 1)) begin
              file_bytes.push_back(CH_STAR);
              file_bytes.push_back(CH_SLASH);
            end
          end
          default: begin
            file_bytes.push_back(CH_SLASH);
            push_text(0, 3);
          end
        endcase
      end
      6: begin
        file_bytes.push_back(8'h78);
        push_text(0, 4);
        if ($urandom_range(0, 1)) begin
          file_bytes.push_back(CH_SLASH);
          file_bytes.push_back(CH_SLASH);
          push_text(0, 3);
        end else push_block_body();
      end
      7: begin
        file_bytes.push_back(CH_SLASH);
        file_bytes.push_back(8'h61);
        push_text(0, 4);
      end
      8: file_bytes.push_back(CH_SLASH);
      default: repeat ($urandom_range(1, 8)) file_bytes.push_back(noise_byte());
    endcase
    if (!last || $urandom_range(0, 1)) file_bytes.push_back(CH_NEWLINE);
  endfunction

  task automatic send_file(int max_lines);
    int nlines;
    nlines = $urandom_range(0, max_lines);
    file_bytes.delete();
    for (int i = 0; i < nlines; i++) push_line(i == nlines - 1);
    foreach (file_bytes[i]) send_item(OP_DATA, file_bytes[i]);
    send_item(OP_EOF, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int  stall_left;
    bit  pressure_taken;
    stall_left     = 0;
    pressure_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_code_lines, out_comment_lines, out_total_lines);
      if (stall_left > 0) stall_left--;
      else if (pressure_go && !pressure_taken) begin
        pressure_taken = 1'b1;
        stall_left     = PRESSURE_HOLD;
      end else if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_ready <= rst_n && (stall_left == 0);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty file, then EOF in several pending states (not ST_BLOCK or ST_AFTER_END).
    send_item(OP_EOF, 8'hFF);
    send_text(" \t\n");
    send_item(OP_DATA, 8'hFF);
    send_text("\n");
    send_item(OP_EOF, 8'h00);
    send_text("/");
    send_item(OP_EOF, 8'hA5);
    send_text("//c");
    send_item(OP_EOF, 8'h5A);
    send_text("/**/ /");
    send_item(OP_EOF, 8'h00);
    send_text("/*\n*");
    send_item(OP_EOF, 8'hFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_EOF, 8'h00);

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      if (!pressure_go && items_sent >= PRESSURE_AT) begin
        // Keep offering short files while the receiver holds off.
        idle_on     = 1'b0;
        pressure_go = 1'b1;
        repeat (PRESSURE_FILES) send_file(1);
        idle_on = 1'b1;
      end else send_file(6);
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    #1;
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
